// ===== rtl/sha256_pkg.sv =====
// SHA-256 package: round constants, initial hash values and shared helper functions.
// Used by all modules of sha256_message_hasher; depends on nothing.
package sha256_pkg;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667;  3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;  3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;  3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;  default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Control from sequencer to round unit
  typedef struct packed {
    logic       start;   // load working vars from chain
    logic       round;   // do one round
    logic       finish;  // add working vars into chain
    logic       reinit;  // chain back to initial hash
    logic [5:0] rnd;     // round index
  } rnd_ctrl_t;

endpackage

// ===== rtl/sha256_round.sv =====
// SHA-256 round unit: chaining words, working variables and one round per cycle.
// Depends on sha256_pkg.
module sha256_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::rnd_ctrl_t ctrl,
  input  sha256_pkg::word_t     w_in,
  input  logic [2:0]            rd_idx,
  output sha256_pkg::word_t     rd_word
);
  import sha256_pkg::*;

  word_t chain_r [8];
  word_t v_r [8];
  word_t t1, t2;

  always_comb begin
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(ctrl.rnd) + w_in;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.reinit) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
    end else if (ctrl.finish) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end else if (ctrl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign rd_word = chain_r[rd_idx];

endmodule

// ===== rtl/sha256_message_hasher.sv =====
// SHA-256 hasher top level: byte intake, block store, padding sequencer, schedule and output.
// Depends on sha256_pkg and sha256_round.
//
// Usage: one byte word is taken per cycle into the 64-byte block store until the block fills;
// each full block then runs 64 compression rounds (one per cycle on the shared round unit)
// plus a setup and a chain update step, during which in_tready is low: no byte is taken
// while a block is being compressed. An end word adds padding at one store write per cycle,
// one or two compressions, then eight digest words on the output, most significant first;
// out_tlast marks the last.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic        out_tlast   // word_last
);
  import sha256_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_FIN   = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_LEN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  word_t       mem [16];   // block store, four bytes per word, first byte in the top lane
  word_t       mem_q;
  logic [3:0]  rd_addr;
  logic [5:0]  wa;
  logic [7:0]  wd;
  logic        we;
  logic [60:0] count_r;
  logic [5:0]  pos_r;      // padding write pointer
  logic        ending_r;   // current compression is part of the final padding
  logic        two_r;      // padding needs a second block
  // pending_end_r: end arrived with the byte that filled a block
  // second_r: the first of two padding blocks has been compressed
  logic        pending_end_r, second_r;
  logic [6:0]  rnd_r;
  logic [2:0]  oidx_r;
  word_t       w_r [16];
  word_t       w_cur, w_new, rd_word;
  logic [63:0] bit_len;
  rnd_ctrl_t   ctrl;
  logic        take;

  assign in_tready = (state_r == S_IDLE);
  assign take = in_tvalid && in_tready;
  assign bit_len = {count_r, 3'b000};

  // store write
  always_comb begin
    we = 1'b0;
    wa = count_r[5:0];
    wd = in_tdata;
    if (take && in_tuser) begin
      we = 1'b1;
    end else if (state_r == S_PAD) begin
      we = 1'b1;
      wa = pos_r;
      wd = (pos_r == count_r[5:0] && !second_r) ? PadByte : 8'h00;
    end else if (state_r == S_LEN) begin
      we = 1'b1;
      wa = pos_r;
      wd = bit_len[8'(7 - pos_r[2:0]) * 8 +: 8];
    end
  end

  // fetch the word for the next round in the cycle before that round
  assign rd_addr = (state_r == S_ROUND) ? rnd_r[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    if (we) mem[wa[5:2]][{~wa[1:0], 3'b000} +: 8] <= wd;
    mem_q <= mem[rd_addr];
  end

  // schedule: first 16 rounds load from store, later rounds from the recurrence
  always_comb begin
    w_cur = mem_q;
    w_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9]
          + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];
    if (rnd_r[6:4] != 3'd0) w_cur = w_new;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_cur;
    end
  end

  always_comb begin
    ctrl.start  = (state_r == S_START);
    ctrl.round  = (state_r == S_ROUND);
    ctrl.finish = (state_r == S_FIN);
    ctrl.reinit = (state_r == S_OUT) && out_tready && (oidx_r == 3'd7);
    ctrl.rnd    = rnd_r[5:0];
  end

  sha256_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .w_in   (w_cur),
    .rd_idx (oidx_r),
    .rd_word(rd_word)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_tuser && count_r[5:0] == 6'd63) state_nxt = S_START;
          else if (in_tlast) state_nxt = S_PAD;
        end
      end
      S_START: state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 7'd63) state_nxt = S_FIN;
      S_FIN: begin
        if (ending_r && !two_r) state_nxt = S_OUT;
        else if (ending_r || pending_end_r) state_nxt = S_PAD;
        else state_nxt = S_IDLE;
      end
      S_PAD: begin
        if (pos_r == 6'd55 && !(two_r && !second_r)) state_nxt = S_LEN;
        else if (pos_r == 6'd63) state_nxt = S_START;
      end
      S_LEN: if (pos_r == 6'd63) state_nxt = S_START;
      S_OUT: if (out_tready && oidx_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      pos_r         <= '0;
      ending_r      <= 1'b0;
      two_r         <= 1'b0;
      second_r      <= 1'b0;
      pending_end_r <= 1'b0;
      rnd_r         <= '0;
      oidx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (take && in_tuser) count_r <= count_r + 61'd1;
      if (take) begin
        pending_end_r <= in_tlast && in_tuser && count_r[5:0] == 6'd63;
        if (in_tlast && !(in_tuser && count_r[5:0] == 6'd63)) begin
          pos_r <= in_tuser ? count_r[5:0] + 6'd1 : count_r[5:0];
          two_r <= (in_tuser ? count_r[5:0] + 6'd1 : count_r[5:0]) > 6'd55;
          second_r <= 1'b0;
        end
      end
      if (state_r == S_START) rnd_r <= '0;
      if (state_r == S_ROUND) rnd_r <= rnd_r + 7'd1;
      if (state_r == S_FIN && pending_end_r) begin
        pending_end_r <= 1'b0;
        pos_r         <= 6'd0;
        two_r         <= 1'b0;
        second_r      <= 1'b0;
      end else if (state_r == S_FIN && ending_r && two_r) begin
        second_r <= 1'b1;
        two_r    <= 1'b0;
        pos_r    <= 6'd0;
      end
      if (state_r == S_PAD || state_r == S_LEN) begin
        pos_r <= pos_r + 6'd1;
        ending_r <= 1'b1;
      end
      if (state_r == S_OUT && out_tready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          count_r  <= '0;
          ending_r <= 1'b0;
          second_r <= 1'b0;
        end
      end
    end
  end

  // The pad byte goes at the message end only in the block that holds it: with two blocks
  // it lands in the first, so the second block is all zeros up to the length.
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = rd_word;
  assign out_tlast  = (oidx_r == 3'd7);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (rnd_r == 7'd64)) else $error("round count wrong");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(oidx_r))) else $error("out dropped");
`endif

endmodule
